[hdl/vze_pkg.sv]
// Package with shared types, constants and helper functions of the varint zigzag encoder.
`timescale 1ns / 1ps

package vze_pkg;

  localparam int VALUE_W      = 64;
  localparam int BYTES_W      = 4;
  localparam int INDEX_W      = 2;
  localparam int GROUP_BITS   = 7;
  localparam logic [6:0] GROUP_MASK = 7'h7F;
  localparam logic [7:0] MORE_FLAG  = 8'h80;

  localparam logic [INDEX_W-1:0] REG_VALUE_BYTES = 2'd0;
  localparam logic [INDEX_W-1:0] REG_SIGNED_MODE = 2'd1;

  localparam logic [BYTES_W-1:0] VALUE_BYTES_RESET = 4'd8;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic more;
  } sts_t;

  // Clamps the configured element size to the range of one to eight bytes.
  function automatic logic [2:0] size_code(input logic [BYTES_W-1:0] vb);
    logic [2:0] code;
    if (vb == '0) begin
      code = 3'd0;
    end else if (vb > 4'd8) begin
      code = 3'd7;
    end else begin
      code = 3'(vb - 4'd1);
    end
    return code;
  endfunction

  // Builds the mask that keeps the low code+1 bytes.
  function automatic logic [VALUE_W-1:0] elem_mask(input logic [2:0] code);
    logic [VALUE_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) <= code) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

[hdl/vze_ctrl.sv]
// Controller state machine that sequences loading and byte emission.
`timescale 1ns / 1ps

module vze_ctrl
  import vze_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.more) begin
            cmd.shift = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/vze_dp.sv]
// Datapath with configuration registers, zigzag mapping and the group shift register.
`timescale 1ns / 1ps

module vze_dp
  import vze_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [BYTES_W-1:0] cfg_data,
  input  logic [VALUE_W-1:0] in_value,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic [7:0]         out_byte,
  output logic               out_last
);

  logic [BYTES_W-1:0] value_bytes_r;
  logic               signed_mode_r;
  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;

  logic [2:0]         code;
  logic [VALUE_W-1:0] mask;
  logic [VALUE_W-1:0] masked;
  logic               neg;
  logic [VALUE_W-1:0] mapped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_bytes_r <= VALUE_BYTES_RESET;
      signed_mode_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_VALUE_BYTES) begin
        value_bytes_r <= cfg_data;
      end else if (cfg_index == REG_SIGNED_MODE) begin
        signed_mode_r <= cfg_data[0];
      end
    end
  end

  always_comb begin
    code   = size_code(value_bytes_r);
    mask   = elem_mask(code);
    masked = in_value & mask;
    neg    = masked[{code, 3'b111}];
    if (signed_mode_r) begin
      mapped = ((masked << 1) ^ (neg ? mask : '0)) & mask;
    end else begin
      mapped = masked;
    end
  end

  always_comb begin
    priority if (cmd.load) begin
      data_nxt = mapped;
    end else if (cmd.shift) begin
      data_nxt = data_r >> GROUP_BITS;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign sts.more = (data_r[VALUE_W-1:GROUP_BITS] != '0);
  assign out_byte = {1'b0, data_r[GROUP_BITS-1:0] & GROUP_MASK} | (sts.more ? MORE_FLAG : 8'h00);
  assign out_last = !sts.more;

endmodule

[hdl/varint_zigzag_encoder.sv]
// Top level of the LEB128 varint encoder with optional zigzag mapping.
`timescale 1ns / 1ps

// Each request carries one element that is masked to value_bytes bytes, zigzag mapped at that
// width when signed_mode is set, and sent out least-significant first as 7-bit groups, one byte
// per output request, bit 7 set on every byte but the last. A zero element gives one 0x00 byte.
// One element is loaded into the single group shift register in the datapath and shifted out one
// 7-bit group per output byte; a new element is taken only after the last byte of the previous
// one has been delivered, while a stalled output holds the current byte.
// Configuration writes are meant for idle periods.
module varint_zigzag_encoder
  import vze_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [BYTES_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last
);

  cmd_t cmd;
  sts_t sts;

  vze_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  vze_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_value  (in_value),
    .cmd       (cmd),
    .sts       (sts),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

[bench/tb_varint_zigzag_encoder.sv]
// Self-checking testbench for the varint zigzag encoder with random handshake pressure.
`timescale 1ns / 1ps

module tb_varint_zigzag_encoder;
  import vze_pkg::*;

  localparam logic [INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [INDEX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 100;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } enc_byte_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [BYTES_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte;
  logic               out_last;

  logic [VALUE_W-1:0] pending_values[$];
  enc_byte_t          expected_bytes[$];
  logic [BYTES_W-1:0] model_bytes = VALUE_BYTES_RESET;
  logic               model_signed = 1'b0;
  int                 queued_count = 0;
  int                 accepted_count = 0;
  int                 errors = 0;
  int                 idle_cycles = 0;
  logic               calm = 1'b0;
  logic               hold_armed = 1'b0;

  varint_zigzag_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Computes the bytes that one element turns into under the current register values.
  function automatic void encode_varint(input logic [VALUE_W-1:0] raw);
    int nbytes;
    int width;
    int bits;
    int ngroups;
    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] v;
    enc_byte_t b;
    nbytes = (model_bytes == 0) ? 1 : (model_bytes > 8) ? 8 : int'(model_bytes);
    width = nbytes * 8;
    mask = (width == VALUE_W) ? '1 : (64'd1 << width) - 64'd1;
    v = raw & mask;
    if (model_signed) begin
      v = ((v << 1) ^ (v[width-1] ? mask : '0)) & mask;
    end
    bits = 0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (v[i]) bits = i + 1;
    end
    ngroups = (bits + GROUP_BITS - 1) / GROUP_BITS;
    if (ngroups == 0) ngroups = 1;
    for (int k = 0; k < ngroups; k++) begin
      b.code = {1'b0, 7'(v >> (k * GROUP_BITS))};
      b.last = (k == ngroups - 1);
      if (!b.last) b.code = b.code | MORE_FLAG;
      expected_bytes.push_back(b);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    int k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: v = v >> $urandom_range(0, 63);
      1: begin
        k = $urandom_range(1, 63);
        v = (64'd1 << k) - 64'($urandom_range(0, 1));
      end
      2: v = ~(v >> $urandom_range(1, 63));
      3: v = {v[63:32], 32'd0};
      4: v = '0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic push_value(input logic [VALUE_W-1:0] v);
    pending_values.push_back(v);
    queued_count++;
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [BYTES_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_VALUE_BYTES) model_bytes = data;
    else if (idx == REG_SIGNED_MODE) model_signed = data[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || expected_bytes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_proc
    logic busy;
    int   in_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        encode_varint(in_value);
        accepted_count++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_values.size() != 0) begin
          in_value <= pending_values.pop_front();
          busy = 1'b1;
          in_gap = calm ? 0 : pick_gap();
        end
      end
      in_valid <= busy;
    end
  end

  always @(posedge clk) begin : check_proc
    enc_byte_t want;
    logic stall;
    int   stall_left;
    int   hold_left;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                 $time, out_byte, out_last);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.code) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, want.code, out_byte);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last mismatch: expected %0b, actual %0b",
                   $time, want.last, out_last);
          errors++;
        end
      end
      if (hold_armed) begin
        hold_left = HOLD_CYCLES;
        hold_armed <= 1'b0;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      stall = 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      stall = 1'b1;
    end else begin
      stall = 1'b0;
    end
    out_stall <= stall;
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("varint_zigzag_encoder regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [BYTES_W-1:0] vb;
    logic               sm;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: 64-bit unsigned, group boundaries and the ten-byte case.
    push_value(64'd0);
    push_value(64'd1);
    push_value(64'd127);
    push_value(64'd128);
    push_value(64'd16383);
    push_value(64'd16384);
    push_value(64'hFFFF_FFFF_FFFF_FFFF);
    push_value(64'h8000_0000_0000_0000);
    push_value(64'h7FFF_FFFF_FFFF_FFFF);
    wait_drained();

    write_reg(REG_SIGNED_MODE, 4'd1);
    push_value(64'd0);
    push_value(64'hFFFF_FFFF_FFFF_FFFF);
    push_value(64'd1);
    push_value(64'h7FFF_FFFF_FFFF_FFFF);
    push_value(64'h8000_0000_0000_0000);
    push_value(64'hFFFF_FFFF_FFFF_FFC0);
    wait_drained();

    // One-byte elements with garbage above the element.
    write_reg(REG_VALUE_BYTES, 4'd1);
    push_value(64'hABCD_EF01_2345_6780);
    push_value(64'h5432_10FE_DCBA_987F);
    push_value(64'hFFFF_FFFF_FFFF_FFFF);
    push_value(64'hFFFF_FFFF_FFFF_FF00);
    wait_drained();

    // A size of zero saturates to one byte; writes to unused indexes change nothing.
    write_reg(REG_VALUE_BYTES, 4'd0);
    write_reg(REG_SIGNED_MODE, 4'd0);
    write_reg(REG_SPARE_2, 4'hF);
    write_reg(REG_SPARE_3, 4'hF);
    push_value(64'hFFFF_FFFF_FFFF_FFFF);
    wait_drained();

    // Sizes above eight saturate to eight bytes.
    write_reg(REG_VALUE_BYTES, 4'd15);
    push_value(64'hFFFF_FFFF_FFFF_FFFF);
    push_value(64'h0123_4567_89AB_CDEF);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin vb = 4'd8; sm = 1'b0; end
        1: begin vb = 4'd1; sm = 1'b1; end
        2: begin vb = 4'd8; sm = 1'b1; end
        3: begin vb = 4'd1; sm = 1'b0; end
        default: begin
          vb = 4'($urandom_range(0, 15));
          sm = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(REG_VALUE_BYTES, vb);
      write_reg(REG_SIGNED_MODE, {3'($urandom_range(0, 7)), sm});
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 4'($urandom_range(0, 15)));
      end
      calm = (p == 2) || ($urandom_range(0, 5) == 0);
      if (p == 4) hold_armed <= 1'b1;
      repeat (25) push_value(rand_value());
      wait_drained();
    end

    calm = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("varint_zigzag_encoder regression: pass");
    end else begin
      $display("varint_zigzag_encoder regression: fail");
    end
    $finish;
  end

endmodule

[varint_zigzag_encoder.f]
hdl/vze_pkg.sv
hdl/vze_ctrl.sv
hdl/vze_dp.sv
hdl/varint_zigzag_encoder.sv
bench/tb_varint_zigzag_encoder.sv
